>>> hw/rtl/hqt_pkg.sv
// ----------------------------------------------------------------------------
// hqt_pkg
// shared widths, operation and status codes and entry types of the quota table
// ----------------------------------------------------------------------------
package hqt_pkg;

    localparam int FUNC_W  = 3;
    localparam int ID_W    = 6;
    localparam int QUOTA_W = 20;
    localparam int CNT_W   = 4;
    localparam int ST_W    = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SPLIT   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CONSUME = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_REFUSED   = 3'd1;
    localparam logic [ST_W-1:0] ST_UNUSED    = 3'd2;
    localparam logic [ST_W-1:0] ST_CHILD_OVF = 3'd3;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd4;

    typedef struct packed {
        logic [QUOTA_W-1:0] quota;
        logic [QUOTA_W-1:0] usage;
        logic [ID_W-1:0]    parent;
        logic [CNT_W-1:0]   children;
    } entry_t;

    typedef struct packed {
        entry_t             ent;
        logic [ID_W-1:0]    new_child;
        logic               granted;
        logic [ST_W-1:0]    status;
    } result_t;

endpackage

>>> hw/rtl/hqt_mem.sv
// ----------------------------------------------------------------------------
// hqt_mem
// entry memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module hqt_mem
    import hqt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/hqt_exec.sv
// ----------------------------------------------------------------------------
// hqt_exec
// operation logic: decides the updated entry, the child slot and the result
// ----------------------------------------------------------------------------
module hqt_exec
    import hqt_pkg::*;
#(
    parameter int ID_COUNT = 64,
    parameter int FAN_OUT  = 8,
    parameter int MEM_N    = 64,
    parameter int AW       = 6
) (
    input  logic [FUNC_W-1:0]  func,
    input  logic [ID_W-1:0]    id,
    input  logic [QUOTA_W-1:0] amount,
    input  logic               unused,
    input  entry_t             cur,
    output result_t            res,
    output logic               upd,
    output logic               split_ok,
    output logic               child_in_mem,
    output logic [AW-1:0]      child_addr
);

    localparam int CW = ID_W + $clog2(FAN_OUT + 1) + 1;

    logic [QUOTA_W-1:0] left;
    logic [CW-1:0]      child_idx;
    logic               child_full;

    assign left       = (cur.usage > cur.quota) ? '0 : cur.quota - cur.usage;
    assign child_idx  = CW'(id) * CW'(FAN_OUT) + CW'(1) + CW'(cur.children);
    assign child_full = (32'(cur.children) >= 32'(FAN_OUT)) || (cur.children >= CNT_MAX)
                        || (32'(child_idx) >= 32'(ID_COUNT));
    assign child_in_mem = 32'(child_idx) < 32'(MEM_N);
    assign child_addr   = child_idx[AW-1:0];

    always_comb
    begin
        res           = '0;
        res.ent       = cur;
        res.status    = ST_OK;
        upd           = 1'b0;
        split_ok      = 1'b0;
        if (unused)
        begin
            res        = '0;
            res.status = ST_UNUSED;
        end
        else
        begin
            case (func)
                FUNC_QUERY:
                begin
                end
                FUNC_SPLIT:
                begin
                    if (child_full)
                    begin
                        res.status = ST_CHILD_OVF;
                    end
                    else if (amount > left)
                    begin
                        res.status = ST_REFUSED;
                    end
                    else
                    begin
                        res.ent.children = cur.children + CNT_W'(1);
                        res.ent.usage    = cur.usage + amount;
                        res.new_child    = child_idx[ID_W-1:0];
                        upd              = 1'b1;
                        split_ok         = 1'b1;
                    end
                end
                FUNC_ALLOC:
                begin
                    if (cur.usage < cur.quota)
                    begin
                        res.ent.usage = cur.usage + QUOTA_W'(1);
                        res.granted   = 1'b1;
                        upd           = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_REFUSED;
                    end
                end
                FUNC_FREE:
                begin
                    if (cur.usage == '0)
                    begin
                        res.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        res.ent.usage = cur.usage - QUOTA_W'(1);
                        upd           = 1'b1;
                    end
                end
                FUNC_CONSUME:
                begin
                    if (left >= amount)
                    begin
                        res.granted = 1'b1;
                    end
                    else
                    begin
                        res.status = ST_REFUSED;
                    end
                end
                default:
                begin
                    res.status = ST_REFUSED;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/hierarchical_quota_table.sv
// ----------------------------------------------------------------------------
// hierarchical_quota_table
// page quota table arranged as a tree of fixed fan-out, one entry per id
// ----------------------------------------------------------------------------
// usage:
//   a request (func, entry_id, amount) is taken at a clock edge with start
//   high and busy low. the entry is read from a synchronous memory at that
//   edge, modified in the following cycle and written back at its end, when
//   the result is registered. done is high for exactly one cycle with the
//   result fields; done and the result are registered together at the end
//   of the modify cycle. the receiver cannot stall. every request except a
//   split that succeeds with its child slot inside the memory returns to idle
//   after the modify cycle, so busy is already low while done is high. such a
//   split writes the new child entry in a further busy state through the
//   single memory write port.
//   root_quota is written with root_quota_we while no request is in flight;
//   it is the quota of entry zero.
//   reset clears the state machine, the in-use bits (entry zero stays in use)
//   and the root quota; entry zero reads as empty until first written.
// ----------------------------------------------------------------------------
module hierarchical_quota_table
    import hqt_pkg::*;
#(
    parameter int ID_COUNT = 64,
    parameter int FAN_OUT  = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               root_quota_we,
    input  logic [QUOTA_W-1:0] root_quota,
    input  logic               start,
    output logic               busy,
    input  logic [FUNC_W-1:0]  func,
    input  logic [ID_W-1:0]    entry_id,
    input  logic [QUOTA_W-1:0] amount,
    output logic               done,
    output logic [QUOTA_W-1:0] quota_out,
    output logic [QUOTA_W-1:0] usage_out,
    output logic [ID_W-1:0]    parent_out,
    output logic [CNT_W-1:0]   children_out,
    output logic [ID_W-1:0]    new_child,
    output logic               granted,
    output logic [ST_W-1:0]    status
);

    localparam int MEM_N = (ID_COUNT < (2 ** ID_W)) ? ID_COUNT : (2 ** ID_W);
    localparam int AW    = $clog2(MEM_N);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_CHILD = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]    id_reg;
    logic [QUOTA_W-1:0] amount_reg;
    logic [QUOTA_W-1:0] root_quota_reg;
    logic               root_fresh_reg;
    logic [MEM_N-1:0]   in_use_reg;
    logic [AW-1:0]      child_addr_reg;
    logic               done_reg;
    result_t            result_reg;

    logic               accept;
    logic               unused;
    entry_t             rd_data;
    entry_t             cur;
    result_t            res;
    logic               upd;
    logic               split_ok;
    logic               child_in_mem;
    logic [AW-1:0]      child_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_data;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign unused = (32'(id_reg) >= 32'(MEM_N)) || !in_use_reg[id_reg[AW-1:0]];

    // entry zero: quota lives in the register, other fields empty until written
    always_comb
    begin
        cur = rd_data;
        if (id_reg == '0)
        begin
            cur.quota = root_quota_reg;
            if (root_fresh_reg)
            begin
                cur.usage    = '0;
                cur.parent   = '0;
                cur.children = '0;
            end
        end
    end

    hqt_mem #(
        .DEPTH (MEM_N),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (entry_id[AW-1:0]),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    hqt_exec #(
        .ID_COUNT (ID_COUNT),
        .FAN_OUT  (FAN_OUT),
        .MEM_N    (MEM_N),
        .AW       (AW)
    ) u_exec (
        .func         (func_reg),
        .id           (id_reg),
        .amount       (amount_reg),
        .unused       (unused),
        .cur          (cur),
        .res          (res),
        .upd          (upd),
        .split_ok     (split_ok),
        .child_in_mem (child_in_mem),
        .child_addr   (child_addr)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = id_reg[AW-1:0];
        wr_data = res.ent;
        if (state_reg == S_EXEC)
        begin
            wr_en = upd;
        end
        else if (state_reg == S_CHILD)
        begin
            wr_en            = 1'b1;
            wr_addr          = child_addr_reg;
            wr_data.quota    = amount_reg;
            wr_data.usage    = '0;
            wr_data.parent   = id_reg;
            wr_data.children = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = (split_ok && child_in_mem) ? S_CHILD : S_IDLE;
            end
            S_CHILD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_quota_reg <= '0;
            root_fresh_reg <= 1'b1;
            in_use_reg     <= MEM_N'(1);
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
            if (root_quota_we)
            begin
                root_quota_reg <= root_quota;
            end
            if ((state_reg == S_EXEC) && upd && (id_reg == '0))
            begin
                root_fresh_reg <= 1'b0;
            end
            if ((state_reg == S_EXEC) && split_ok && child_in_mem)
            begin
                in_use_reg[child_addr] <= 1'b1;
            end
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg   <= func;
            id_reg     <= entry_id;
            amount_reg <= amount;
        end
        if (state_reg == S_EXEC)
        begin
            result_reg     <= res;
            child_addr_reg <= child_addr;
        end
    end

    assign done         = done_reg;
    assign quota_out    = result_reg.ent.quota;
    assign usage_out    = result_reg.ent.usage;
    assign parent_out   = result_reg.ent.parent;
    assign children_out = result_reg.ent.children;
    assign new_child    = result_reg.new_child;
    assign granted      = result_reg.granted;
    assign status       = result_reg.status;

endmodule
